[rtl/cpsq_pkg.sv]
// ----------------------------------------------------------------------------
// cpsq_pkg
// Shared types and constants for the contactor precharge sequencer.
// ----------------------------------------------------------------------------
package cpsq_pkg;

    localparam int VOLT_WIDTH  = 16;
    localparam int TEMP_WIDTH  = 10;
    localparam int DUTY_WIDTH  = 8;
    localparam int PCT_WIDTH   = 7;
    localparam int GAIN_WIDTH  = 8;
    localparam int TIMER_WIDTH = 24;
    localparam int CFG_DATA_WIDTH = 24;
    localparam int CFG_IDX_WIDTH  = 3;

    // pack * percent and inverter * 100 share one width
    localparam int PROD_WIDTH = VOLT_WIDTH + PCT_WIDTH;
    localparam int DUTY_SUM_WIDTH = GAIN_WIDTH + TEMP_WIDTH + 1;

    localparam logic [DUTY_WIDTH-1:0] DUTY_MAX = {DUTY_WIDTH{1'b1}};
    localparam logic [PROD_WIDTH-1:0] PERCENT_SCALE = PROD_WIDTH'(100);

    // bit 0 air+, 1 air-, 2 pump, 3 converter inhibit, 4 precharge, 5 discharge, 6 fan
    localparam logic [6:0] BITS_OFF = 7'h08;
    localparam logic [6:0] BITS_PRE = 7'h3A;
    localparam logic [6:0] BITS_ON  = 7'h23;
    localparam logic [6:0] BITS_DRV = 7'h67;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_PRECHARGE_TIMEOUT = 3'd0,
        CFG_PRECHARGE_PERCENT = 3'd1,
        CFG_DRIVE_DELAY       = 3'd2,
        CFG_FAN_SLOPE         = 3'd3,
        CFG_FAN_BIAS          = 3'd4,
        CFG_FAN_DUTY_MIN      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TIMER_WIDTH-1:0] precharge_timeout;
        logic [PCT_WIDTH-1:0]   precharge_percent;
        logic [TIMER_WIDTH-1:0] drive_delay;
        logic [GAIN_WIDTH-1:0]  fan_slope;
        logic [DUTY_WIDTH-1:0]  fan_bias;
        logic [DUTY_WIDTH-1:0]  fan_duty_min;
    } cfg_t;

    typedef struct packed {
        logic                  ts_ready;
        logic                  charger_present;
        logic [VOLT_WIDTH-1:0] inverter_voltage;
        logic [VOLT_WIDTH-1:0] pack_voltage;
        logic [TEMP_WIDTH-1:0] pack_temperature;
    } in_t;

    typedef struct packed {
        logic                  air_positive;
        logic                  air_negative;
        logic                  pump_enable;
        logic                  conv_inhibit;
        logic                  precharge_relay;
        logic                  discharge_relay;
        logic                  fan_enable;
        logic [DUTY_WIDTH-1:0] fan_duty;
        logic                  precharge_fail;
        logic [2:0]            sequence_state;
    } out_t;

    // precomputed terms handed from the input stage to the sequencer
    typedef struct packed {
        logic                  ts_ready;
        logic                  charger_present;
        logic [PROD_WIDTH-1:0] pack_scaled;
        logic [PROD_WIDTH-1:0] inv_scaled;
        logic [DUTY_WIDTH-1:0] drive_duty;
    } pre_t;

endpackage

[rtl/cpsq_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cpsq_cfg_regs
// Configuration register file, written over its own valid/ready channel.
// ----------------------------------------------------------------------------
module cpsq_cfg_regs
    import cpsq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.precharge_timeout <= TIMER_WIDTH'(1000);
            cfg_reg.precharge_percent <= PCT_WIDTH'(90);
            cfg_reg.drive_delay       <= TIMER_WIDTH'(500);
            cfg_reg.fan_slope         <= GAIN_WIDTH'(1);
            cfg_reg.fan_bias          <= '0;
            cfg_reg.fan_duty_min      <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_PRECHARGE_TIMEOUT: cfg_reg.precharge_timeout <= cfg_data[TIMER_WIDTH-1:0];
                CFG_PRECHARGE_PERCENT: cfg_reg.precharge_percent <= cfg_data[PCT_WIDTH-1:0];
                CFG_DRIVE_DELAY:       cfg_reg.drive_delay       <= cfg_data[TIMER_WIDTH-1:0];
                CFG_FAN_SLOPE:         cfg_reg.fan_slope         <= cfg_data[GAIN_WIDTH-1:0];
                CFG_FAN_BIAS:          cfg_reg.fan_bias          <= cfg_data[DUTY_WIDTH-1:0];
                CFG_FAN_DUTY_MIN:      cfg_reg.fan_duty_min      <= cfg_data[DUTY_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/cpsq_pre.sv]
// ----------------------------------------------------------------------------
// cpsq_pre
// Input stage: registers the item together with the scaled voltages and the
// saturated fan duty, so the sequencer stage only compares and selects.
// ----------------------------------------------------------------------------
module cpsq_pre
    import cpsq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    input  cfg_t cfg,
    output logic out_valid,
    input  logic out_ready,
    output pre_t out_data
);

    logic                      valid_reg;
    pre_t                      data_reg;
    pre_t                      data_next;
    logic [DUTY_SUM_WIDTH-1:0] duty_sum;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        duty_sum = DUTY_SUM_WIDTH'(cfg.fan_slope) * DUTY_SUM_WIDTH'(in_data.pack_temperature)
                 + DUTY_SUM_WIDTH'(cfg.fan_bias);
        data_next.ts_ready        = in_data.ts_ready;
        data_next.charger_present = in_data.charger_present;
        // threshold = pack * percent / 100 is never formed; compares are scaled by 100
        data_next.pack_scaled = PROD_WIDTH'(in_data.pack_voltage)
                              * PROD_WIDTH'(cfg.precharge_percent);
        data_next.inv_scaled  = PROD_WIDTH'(in_data.inverter_voltage) * PERCENT_SCALE;
        data_next.drive_duty  = (duty_sum > DUTY_SUM_WIDTH'(DUTY_MAX)) ?
                                DUTY_MAX : duty_sum[DUTY_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/cpsq_seq.sv]
// ----------------------------------------------------------------------------
// cpsq_seq
// Sequencer stage: state, tick counter, fail flag and the held output
// registers, which also form the result register.
// ----------------------------------------------------------------------------
module cpsq_seq
    import cpsq_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  pre_t in_data,
    input  cfg_t cfg,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > TIMER_WIDTH) ? COUNT_WIDTH : TIMER_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        ST_OFF = 3'd0,
        ST_PRE = 3'd1,
        ST_ON  = 3'd2,
        ST_CHG = 3'd3,
        ST_DRV = 3'd4
    } state_t;

    state_t                 state_reg,  state_next;
    logic [COUNT_WIDTH-1:0] tick_reg,   tick_next;
    logic                   failed_reg, failed_next;
    logic [6:0]             bits_reg,   bits_next;
    logic [DUTY_WIDTH-1:0]  duty_reg,   duty_next;
    logic                   m_valid_reg;

    logic                   take;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic                   pre_timed_out;
    logic                   drv_elapsed;
    logic                   inv_below;
    logic                   inv_above;

    assign in_ready = !m_valid_reg || m_ready;
    assign take     = in_valid && in_ready;
    assign m_valid  = m_valid_reg;

    assign tick_inc      = (tick_reg == COUNT_MAX) ? tick_reg : tick_reg + 1'b1;
    assign pre_timed_out = CMP_WIDTH'(tick_reg) > CMP_WIDTH'(cfg.precharge_timeout);
    assign drv_elapsed   = CMP_WIDTH'(tick_reg) > CMP_WIDTH'(cfg.drive_delay);
    // inv < floor(P/100)  <=>  100*inv + 100 <= P ;  inv > floor(P/100)  <=>  100*inv > P
    assign inv_below = ({1'b0, in_data.inv_scaled} + {1'b0, PERCENT_SCALE})
                       <= {1'b0, in_data.pack_scaled};
    assign inv_above = in_data.inv_scaled > in_data.pack_scaled;

    always_comb begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        failed_next = failed_reg;
        bits_next   = bits_reg;
        duty_next   = duty_reg;
        case (state_reg)
            ST_PRE: begin
                bits_next = BITS_PRE;
                duty_next = cfg.fan_duty_min;
                if ((pre_timed_out && inv_below && !in_data.charger_present)
                    || !in_data.ts_ready) begin
                    failed_next = 1'b1;
                    state_next  = ST_OFF;
                end else if ((pre_timed_out && inv_above) || in_data.charger_present) begin
                    state_next = ST_ON;
                end else begin
                    tick_next = tick_inc;
                end
            end
            ST_ON: begin
                bits_next = BITS_ON;
                duty_next = cfg.fan_duty_min;
                if (!in_data.ts_ready) begin
                    state_next = ST_OFF;
                end else if (in_data.charger_present) begin
                    state_next = ST_CHG;
                end else begin
                    state_next = ST_DRV;
                    tick_next  = '0;
                end
            end
            ST_CHG: begin
                bits_next = BITS_ON;
                duty_next = cfg.fan_duty_min;
                if (!in_data.ts_ready) begin
                    state_next = ST_OFF;
                end
            end
            ST_DRV: begin
                // outputs stay as the contactors-on state left them until the delay runs out
                if (drv_elapsed) begin
                    bits_next = BITS_DRV;
                    duty_next = in_data.drive_duty;
                end else begin
                    tick_next = tick_inc;
                end
                if (!in_data.ts_ready) begin
                    state_next = ST_OFF;
                end
            end
            default: begin
                bits_next = BITS_OFF;
                duty_next = cfg.fan_duty_min;
                if (in_data.ts_ready) begin
                    failed_next = 1'b0;
                    state_next  = ST_PRE;
                    tick_next   = '0;
                end else begin
                    state_next = ST_OFF;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_OFF;
            tick_reg    <= '0;
            failed_reg  <= 1'b0;
            bits_reg    <= '0;
            duty_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                state_reg  <= state_next;
                tick_reg   <= tick_next;
                failed_reg <= failed_next;
                bits_reg   <= bits_next;
                duty_reg   <= duty_next;
            end
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        m_data.air_positive    = bits_reg[0];
        m_data.air_negative    = bits_reg[1];
        m_data.pump_enable     = bits_reg[2];
        m_data.conv_inhibit    = bits_reg[3];
        m_data.precharge_relay = bits_reg[4];
        m_data.discharge_relay = bits_reg[5];
        m_data.fan_enable      = bits_reg[6];
        m_data.fan_duty        = duty_reg;
        m_data.precharge_fail  = failed_reg;
        m_data.sequence_state  = state_reg;
    end

endmodule

[rtl/contactor_precharge_sequencer_core.sv]
// ----------------------------------------------------------------------------
// contactor_precharge_sequencer_core
// High-voltage contactor and precharge sequencer, one control tick per item.
// ----------------------------------------------------------------------------
// Takes one item per clock while m_ready is held high and returns one result per
// item from the sequencer registers. An input stage registers the item with
// the pack and inverter voltages already scaled for the precharge threshold
// compare and the fan duty already saturated; the second stage is the state
// register, tick counter and held outputs, updated in a single pass per item.
// The result shows the output registers and the state after the item's tick.
// Configuration writes are taken at any time (cfg_ready is always high) and
// are meant to land while no item is in flight; unknown indices are ignored.
module contactor_precharge_sequencer_core
    import cpsq_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  in_t                       s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output out_t                      m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    cfg_t cfg;
    pre_t pre_data;
    logic pre_valid;
    logic pre_ready;

    cpsq_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cpsq_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .cfg       (cfg),
        .out_valid (pre_valid),
        .out_ready (pre_ready),
        .out_data  (pre_data)
    );

    cpsq_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pre_valid),
        .in_ready (pre_ready),
        .in_data  (pre_data),
        .cfg      (cfg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[sim/tb_contactor_precharge_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contactor_precharge_sequencer_core
// Self-checking bench for the HV contactor and precharge sequencer.
// ----------------------------------------------------------------------------
// A tick-level copy of the sequencer predicts one output item per accepted
// control tick. A short directed trace walks every state and edge case, then
// phases of random ticks, shaped by the predicted state, run under different
// register settings with random back-pressure and source gaps.
// ----------------------------------------------------------------------------

import cpsq_pkg::*;

typedef enum logic [2:0] {
    SEQ_OFF       = 3'd0,
    SEQ_PRECHARGE = 3'd1,
    SEQ_ON        = 3'd2,
    SEQ_CHARGE    = 3'd3,
    SEQ_DRIVE     = 3'd4
} seq_state_t;

class sequence_scoreboard;

    localparam longint unsigned PERCENT_DIV = 100;
    localparam int MAX_PRINTED = 40;

    cfg_t        regs;
    seq_state_t  state_q;
    logic [23:0] tick_count;
    logic        failed;
    logic [6:0]  drive_bits;
    logic [7:0]  duty_hold;
    out_t        expected_outputs[$];
    int          errors;
    int          results_seen;

    function new();
        regs.precharge_timeout = 24'd1000;
        regs.precharge_percent = 7'd90;
        regs.drive_delay       = 24'd500;
        regs.fan_slope         = 8'd1;
        regs.fan_bias          = 8'd0;
        regs.fan_duty_min      = 8'd0;
        state_q      = SEQ_OFF;
        tick_count   = '0;
        failed       = 1'b0;
        drive_bits   = '0;
        duty_hold    = '0;
        errors       = 0;
        results_seen = 0;
    endfunction

    function int pending();
        return expected_outputs.size();
    endfunction

    function void write_register(logic [CFG_IDX_WIDTH-1:0] idx, logic [23:0] d);
        case (idx)
            CFG_PRECHARGE_TIMEOUT: regs.precharge_timeout = d;
            CFG_PRECHARGE_PERCENT: regs.precharge_percent = d[6:0];
            CFG_DRIVE_DELAY:       regs.drive_delay       = d;
            CFG_FAN_SLOPE:         regs.fan_slope         = d[7:0];
            CFG_FAN_BIAS:          regs.fan_bias          = d[7:0];
            CFG_FAN_DUTY_MIN:      regs.fan_duty_min      = d[7:0];
            default: ;
        endcase
    endfunction

    function void count_up();
        if (tick_count != '1)
            tick_count = tick_count + 1'b1;
    endfunction

    // one control tick: held outputs from the current state, then the transition
    function void note_tick(in_t t);
        out_t            o;
        longint unsigned thr;
        int unsigned     duty;
        bit              timed_out;
        case (state_q)
            SEQ_PRECHARGE: begin
                drive_bits = BITS_PRE;
                duty_hold  = regs.fan_duty_min;
                thr = (longint'(t.pack_voltage) * longint'(regs.precharge_percent)) / PERCENT_DIV;
                timed_out = (tick_count > regs.precharge_timeout);
                if ((timed_out && t.inverter_voltage < thr && !t.charger_present) ||
                    !t.ts_ready) begin
                    failed  = 1'b1;
                    state_q = SEQ_OFF;
                end else if ((timed_out && t.inverter_voltage > thr) ||
                             t.charger_present) begin
                    state_q = SEQ_ON;
                end else begin
                    count_up();
                end
            end
            SEQ_ON: begin
                drive_bits = BITS_ON;
                duty_hold  = regs.fan_duty_min;
                if (!t.ts_ready) begin
                    state_q = SEQ_OFF;
                end else if (t.charger_present) begin
                    state_q = SEQ_CHARGE;
                end else begin
                    state_q    = SEQ_DRIVE;
                    tick_count = '0;
                end
            end
            SEQ_CHARGE: begin
                drive_bits = BITS_ON;
                duty_hold  = regs.fan_duty_min;
                if (!t.ts_ready)
                    state_q = SEQ_OFF;
            end
            SEQ_DRIVE: begin
                // outputs left as the contactors-on state wrote them until the delay is up
                if (tick_count > regs.drive_delay) begin
                    drive_bits = BITS_DRV;
                    duty = int'(regs.fan_slope) * int'(t.pack_temperature) +
                           int'(regs.fan_bias);
                    duty_hold = (duty > DUTY_MAX) ? DUTY_MAX : duty[7:0];
                end else begin
                    count_up();
                end
                if (!t.ts_ready)
                    state_q = SEQ_OFF;
            end
            default: begin
                drive_bits = BITS_OFF;
                duty_hold  = regs.fan_duty_min;
                if (t.ts_ready) begin
                    failed     = 1'b0;
                    state_q    = SEQ_PRECHARGE;
                    tick_count = '0;
                end else begin
                    state_q = SEQ_OFF;
                end
            end
        endcase
        o.air_positive    = drive_bits[0];
        o.air_negative    = drive_bits[1];
        o.pump_enable     = drive_bits[2];
        o.conv_inhibit    = drive_bits[3];
        o.precharge_relay = drive_bits[4];
        o.discharge_relay = drive_bits[5];
        o.fan_enable      = drive_bits[6];
        o.fan_duty        = duty_hold;
        o.precharge_fail  = failed;
        o.sequence_state  = state_q;
        expected_outputs.push_back(o);
    endfunction

    task report(string msg);
        if (errors < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report($sformatf("item %0d %s got %0h want %0h", results_seen, name, got, want));
    endtask

    task check_outputs(out_t got);
        out_t want;
        if (expected_outputs.size() == 0) begin
            report("output item with no tick waiting");
            return;
        end
        want = expected_outputs.pop_front();
        check_field("air_positive",    got.air_positive,    want.air_positive);
        check_field("air_negative",    got.air_negative,    want.air_negative);
        check_field("pump_enable",     got.pump_enable,     want.pump_enable);
        check_field("conv_inhibit",    got.conv_inhibit,    want.conv_inhibit);
        check_field("precharge_relay", got.precharge_relay, want.precharge_relay);
        check_field("discharge_relay", got.discharge_relay, want.discharge_relay);
        check_field("fan_enable",      got.fan_enable,      want.fan_enable);
        check_field("fan_duty",        got.fan_duty,        want.fan_duty);
        check_field("precharge_fail",  got.precharge_fail,  want.precharge_fail);
        check_field("sequence_state",  got.sequence_state,  want.sequence_state);
        results_seen++;
    endtask

endclass

module tb_contactor_precharge_sequencer_core;

    localparam int PHASES          = 8;
    localparam int TICKS_PER_PHASE = 190;
    localparam int NOISE_PHASE     = 3;
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 8;
    localparam int WATCHDOG_LIMIT  = 1000;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_B = 3'd7;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    in_t                       s_data;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    out_t                      m_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    sequence_scoreboard sb = new();

    bit src_gaps;
    bit sink_gaps;
    int sink_hold = 0;
    int quiet_cycles = 0;

    contactor_precharge_sequencer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // output back-pressure in random bursts
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
            sink_hold <= $urandom_range(0, 7);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_outputs(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_contactor_precharge_sequencer_core: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task send_tick(in_t t);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(t);
    endtask

    task drive_tick(bit rdy, bit chg, logic [15:0] inv, logic [15:0] pack, logic [9:0] temp);
        in_t t;
        t.ts_ready         = rdy;
        t.charger_present  = chg;
        t.inverter_voltage = inv;
        t.pack_voltage     = pack;
        t.pack_temperature = temp;
        send_tick(t);
    endtask

    // wait for every expected output item before touching the registers
    task settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [23:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_register(idx, d);
    endtask

    task program_regs(logic [23:0] timeout, logic [23:0] pct, logic [23:0] delay,
                      logic [23:0] gain, logic [23:0] offset, logic [23:0] duty_min);
        write_reg(CFG_PRECHARGE_TIMEOUT, timeout);
        write_reg(CFG_PRECHARGE_PERCENT, pct);
        write_reg(CFG_DRIVE_DELAY, delay);
        write_reg(CFG_FAN_SLOPE, gain);
        write_reg(CFG_FAN_BIAS, offset);
        write_reg(CFG_FAN_DUTY_MIN, duty_min);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 24'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed sequences: ready held, voltages placed around the threshold
    function in_t random_tick(bit noise);
        in_t             t;
        longint unsigned thr;
        int unsigned     r;
        int unsigned     lim;
        t.ts_ready         = 1'($urandom_range(0, 1));
        t.charger_present  = 1'($urandom_range(0, 1));
        t.inverter_voltage = 16'($urandom_range(0, 65535));
        t.pack_voltage     = 16'($urandom_range(0, 65535));
        t.pack_temperature = 10'($urandom_range(0, 1023));
        if (noise)
            return t;
        r = $urandom_range(0, 9);
        if (r == 0)
            t.pack_voltage = 16'h0000;
        else if (r == 1)
            t.pack_voltage = 16'hFFFF;
        r = $urandom_range(0, 9);
        if (r == 0)
            t.pack_temperature = '0;
        else if (r == 1)
            t.pack_temperature = '1;
        thr = (longint'(t.pack_voltage) * longint'(sb.regs.precharge_percent)) / 100;
        lim = (thr > 65536) ? 32'd65536 : 32'(thr);
        case ($urandom_range(0, 3))
            0: if (thr > 0)
                t.inverter_voltage = 16'($urandom_range(0, lim - 1));
            1: t.inverter_voltage = (thr > 65535) ? 16'hFFFF : thr[15:0];
            2: t.inverter_voltage = (thr >= 65535) ? 16'hFFFF :
                                    16'($urandom_range(32'(thr) + 1, 65535));
            default: ;
        endcase
        case (sb.state_q)
            SEQ_OFF: begin
                t.ts_ready = ($urandom_range(0, 7) != 0);
            end
            SEQ_PRECHARGE: begin
                t.ts_ready        = ($urandom_range(0, 29) != 0);
                t.charger_present = ($urandom_range(0, 9) == 0);
            end
            SEQ_ON: begin
                t.ts_ready        = ($urandom_range(0, 19) != 0);
                t.charger_present = ($urandom_range(0, 2) == 0);
            end
            SEQ_CHARGE: t.ts_ready = ($urandom_range(0, 7) != 0);
            SEQ_DRIVE:  t.ts_ready = ($urandom_range(0, 39) != 0);
            default: ;
        endcase
        return t;
    endfunction

    initial begin
        int ph;
        int n;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: charger skips the precharge wait
        drive_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 10'd1023);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'hFFFF, 10'd0);
        drive_tick(1'b1, 1'b0, 16'hFFFF, 16'h0000, 10'd1023);
        drive_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0);
        settle();

        program_regs(24'd0, 24'd100, 24'd0, 24'd255, 24'd255, 24'h55);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        // inverter exactly on the threshold: stays in precharge
        drive_tick(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 10'd0);
        // low inverter voltage after timeout: failure
        drive_tick(1'b1, 1'b0, 16'h0000, 16'hFFFF, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'hFFFF, 16'd1000, 10'd0);
        drive_tick(1'b1, 1'b1, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0);
        // loss of ready during precharge
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b1, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        // duty at full scale from the offset alone, then saturated by the temperature
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b1, 1'b0, 16'h0000, 16'h0000, 10'd1023);
        drive_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0);
        drive_tick(1'b0, 1'b0, 16'h0000, 16'h0000, 10'd0);

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: program_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
                // percent above 100 puts the threshold past the pack voltage
                1: program_regs(24'd3, 24'd127, 24'd5, 24'd255, 24'd255, 24'd255);
                2: program_regs(24'hFFFFFF, 24'd100, 24'hFFFFFF, 24'($urandom_range(0, 3)),
                                24'($urandom_range(0, 255)), 24'($urandom_range(0, 255)));
                default: program_regs(
                    24'($urandom_range(0, 12)),
                    {17'($urandom_range(0, 131071)),
                     7'(($urandom_range(0, 3) == 0) ? $urandom_range(101, 127)
                                                    : $urandom_range(0, 100))},
                    24'($urandom_range(0, 20)),
                    {16'($urandom_range(0, 65535)),
                     8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                    : $urandom_range(0, 255))},
                    {16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))},
                    {16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255))});
            endcase
            n = (ph == PHASES - 1) ? 0 : $urandom_range(0, 3);
            src_gaps  = n[0];
            sink_gaps = n[1];
            for (n = 0; n < TICKS_PER_PHASE; n++)
                send_tick(random_tick(ph == NOISE_PHASE || $urandom_range(0, 15) == 0));
        end

        settle();
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_contactor_precharge_sequencer_core: PASS");
        else
            $display("tb_contactor_precharge_sequencer_core: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/cpsq_pkg.sv
rtl/cpsq_cfg_regs.sv
rtl/cpsq_pre.sv
rtl/cpsq_seq.sv
rtl/contactor_precharge_sequencer_core.sv
sim/tb_contactor_precharge_sequencer_core.sv
